### design/conveyor_sort_tracker_assert.svh
// ----------------------------------------------------------------------------
// conveyor sort tracker assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CONVEYOR_SORT_TRACKER_ASSERT_SVH
`define CONVEYOR_SORT_TRACKER_ASSERT_SVH

// condition must hold on every clock edge out of reset
`define CST_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("conveyor sort tracker: check failed");

// consequent must hold in the cycle after the antecedent
`define CST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("conveyor sort tracker: check failed");

`endif

### design/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// types, constants and helpers shared by the conveyor sort tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cst_pkg;

	// sizing
	localparam int SLOT_COUNT  = 7;
	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int ARM_COUNT   = 3;
	localparam int CMP_W       = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

	// object classes
	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_SMALL  = 2'd1,
		KIND_MEDIUM = 2'd2,
		KIND_LARGE  = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STEP_TICKS   = CFG_INDEX_W'(0),
		CFG_PULSE_SMALL  = CFG_INDEX_W'(1),
		CFG_PULSE_MEDIUM = CFG_INDEX_W'(2),
		CFG_PULSE_LARGE  = CFG_INDEX_W'(3)
	} cfg_index_t;

	// reset values of the configuration registers
	localparam logic [CFG_WIDTH-1:0] STEP_TICKS_RST   = CFG_WIDTH'(100);
	localparam logic [CFG_WIDTH-1:0] PULSE_SMALL_RST  = CFG_WIDTH'(30);
	localparam logic [CFG_WIDTH-1:0] PULSE_MEDIUM_RST = CFG_WIDTH'(50);
	localparam logic [CFG_WIDTH-1:0] PULSE_LARGE_RST  = CFG_WIDTH'(70);

	// arm stations along the belt, arm order small, medium, large
	localparam int    ARM_STATION [ARM_COUNT] = '{2, 4, 6};
	localparam kind_t ARM_KIND    [ARM_COUNT] = '{KIND_SMALL, KIND_MEDIUM, KIND_LARGE};

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_word_t;

	// configuration as seen by the tracker core
	typedef struct packed {
		cfg_word_t step_ticks;
		cfg_word_t pulse_small_ticks;
		cfg_word_t pulse_medium_ticks;
		cfg_word_t pulse_large_ticks;
	} cfg_t;

	// one tick item
	typedef struct packed {
		logic start_press;
		logic small_present;
		logic medium_seen;
	} req_t;

	// one result item
	typedef struct packed {
		logic       motor_on;
		logic       arm_small;
		logic       arm_medium;
		logic       arm_large;
		logic       stop_event;
		logic [1:0] entering_kind;
	} rsp_t;

	// saturating timer increment
	function automatic timer_t count_up(input timer_t c);
		return (c == '1) ? c : c + timer_t'(1);
	endfunction

endpackage

### design/cst_cfg_regs.sv
// ----------------------------------------------------------------------------
// cst_cfg_regs
// configuration register file; writes to unknown indexes are dropped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cst_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cst_pkg::CFG_WIDTH-1:0]   cfg_data,
	output cst_pkg::cfg_t              cfg
);
	import cst_pkg::*;

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ticks         <= STEP_TICKS_RST;
			cfg_q.pulse_small_ticks  <= PULSE_SMALL_RST;
			cfg_q.pulse_medium_ticks <= PULSE_MEDIUM_RST;
			cfg_q.pulse_large_ticks  <= PULSE_LARGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEP_TICKS:   cfg_q.step_ticks         <= cfg_data;
				CFG_PULSE_SMALL:  cfg_q.pulse_small_ticks  <= cfg_data;
				CFG_PULSE_MEDIUM: cfg_q.pulse_medium_ticks <= cfg_data;
				CFG_PULSE_LARGE:  cfg_q.pulse_large_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### design/cst_core.sv
// ----------------------------------------------------------------------------
// cst_core
// belt phase timer, sort shift register and arm pulse timers for one tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cst_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  cst_pkg::req_t item,
	input  cst_pkg::cfg_t cfg,
	output cst_pkg::rsp_t result
);
	import cst_pkg::*;

	kind_t  slots_q    [SLOT_COUNT];
	logic   stepping_q;
	logic   moving_q;
	timer_t phase_q;
	logic   latch_q;
	logic   [ARM_COUNT-1:0] arm_act_q;
	timer_t arm_cnt_q  [ARM_COUNT];

	kind_t  slots_n    [SLOT_COUNT];
	logic   stepping_n;
	logic   moving_n;
	timer_t phase_n;
	logic   latch_n;
	logic   [ARM_COUNT-1:0] arm_act_n;
	timer_t arm_cnt_n  [ARM_COUNT];
	cfg_word_t pulse_len [ARM_COUNT];
	logic   stop_now;
	kind_t  entering;

	assign pulse_len[0] = cfg.pulse_small_ticks;
	assign pulse_len[1] = cfg.pulse_medium_ticks;
	assign pulse_len[2] = cfg.pulse_large_ticks;

	// next state for one tick
	always_comb begin
		slots_n    = slots_q;
		stepping_n = stepping_q;
		moving_n   = moving_q;
		phase_n    = stepping_q ? count_up(phase_q) : phase_q;
		latch_n    = latch_q | item.medium_seen;
		arm_act_n  = arm_act_q;
		stop_now   = 1'b0;
		entering   = KIND_EMPTY;

		for (int a = 0; a < ARM_COUNT; a++) begin
			arm_cnt_n[a] = arm_act_q[a] ? count_up(arm_cnt_q[a]) : arm_cnt_q[a];
		end

		// start or restart stepping
		if (item.start_press) begin
			stepping_n = 1'b1;
			moving_n   = 1'b1;
			phase_n    = '0;
		end

		// release arms whose pulse has run out
		for (int a = 0; a < ARM_COUNT; a++) begin
			if (arm_act_n[a] && (CMP_W'(arm_cnt_n[a]) >= CMP_W'(pulse_len[a]))) begin
				arm_act_n[a] = 1'b0;
			end
		end

		// phase end: toggle the belt, shift and classify on a stop
		if (stepping_n && (CMP_W'(phase_n) >= CMP_W'(cfg.step_ticks))) begin
			moving_n = ~moving_n;
			phase_n  = '0;
			if (!moving_n) begin
				stop_now = 1'b1;
				for (int s = SLOT_COUNT - 1; s > 0; s--) begin
					slots_n[s] = slots_q[s-1];
				end
				if (!item.small_present) begin
					entering = KIND_EMPTY;
				end else begin
					entering = latch_n ? KIND_MEDIUM : KIND_SMALL;
				end
				slots_n[0] = entering;
				latch_n    = 1'b0;
				for (int a = 0; a < ARM_COUNT; a++) begin
					if (slots_n[ARM_STATION[a]] == ARM_KIND[a]) begin
						arm_act_n[a]            = 1'b1;
						arm_cnt_n[a]            = '0;
						slots_n[ARM_STATION[a]] = KIND_EMPTY;
					end
				end
			end
		end

		result.motor_on      = moving_n;
		result.arm_small     = arm_act_n[0];
		result.arm_medium    = arm_act_n[1];
		result.arm_large     = arm_act_n[2];
		result.stop_event    = stop_now;
		result.entering_kind = entering;
	end

	// state registers, updated as each item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				slots_q[s] <= KIND_EMPTY;
			end
			stepping_q <= 1'b0;
			moving_q   <= 1'b0;
			phase_q    <= '0;
			latch_q    <= 1'b0;
			arm_act_q  <= '0;
			for (int a = 0; a < ARM_COUNT; a++) begin
				arm_cnt_q[a] <= '0;
			end
		end else if (advance) begin
			slots_q    <= slots_n;
			stepping_q <= stepping_n;
			moving_q   <= moving_n;
			phase_q    <= phase_n;
			latch_q    <= latch_n;
			arm_act_q  <= arm_act_n;
			arm_cnt_q  <= arm_cnt_n;
		end
	end

endmodule

### design/conveyor_sort_tracker.sv
// ----------------------------------------------------------------------------
// conveyor_sort_tracker
// stepping belt controller with a sort shift register and three arm timers
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per time tick (start press, small sensor level,
//     medium sensor edge), taken when req_valid is high and req_stall low
//   rsp channel: one result item per tick (motor, three arm levels, stop
//     event, class entering slot 0), taken when rsp_valid high, rsp_stall low
//   cfg channel: register writes by index (0 step ticks, 1..3 arm pulse
//     lengths), taken when cfg_valid and cfg_ready are high; cfg_ready is
//     always high and unknown indexes are ignored
//   path: a taken tick item sits in the input register, then its result lands
//     in the result register and is offered; a stall can hold it in between
//   throughput: one item per cycle while not stalled; the whole tick update is
//     one pass of compare, counter and shift logic between the two registers
//   stall: with the result register full and rsp_stall high the input stage
//     holds its item and raises req_stall; no item is dropped
//   reset: belt idle, motor off, all slots empty, arms off, registers back
//     to their defaults; ready for items as soon as reset is released
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conveyor_sort_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  cst_pkg::req_t                 req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output cst_pkg::rsp_t                 rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cst_pkg::CFG_WIDTH-1:0]   cfg_data
);
	import cst_pkg::*;

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	rsp_t result;
	rsp_t result_s2;
	logic valid_s2;
	logic advance;

	// configuration registers
	cst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// tick update logic and tracker state
	cst_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// item moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = valid_s2;
	assign rsp_data  = result_s2;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_data;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

### design/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// port level checks of the conveyor sort tracker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "conveyor_sort_tracker_assert.svh"

module cst_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input cst_pkg::rsp_t rsp_data
);
	import cst_pkg::*;

	// a stalled result stays offered
	`CST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

	// a class enters slot 0 only on a stop
	`CST_ASSERT_ALWAYS(a_kind_on_stop,
		!rsp_valid || rsp_data.stop_event || (rsp_data.entering_kind == KIND_EMPTY))

	// the large class is never produced
	`CST_ASSERT_ALWAYS(a_no_large, !rsp_valid || (rsp_data.entering_kind != KIND_LARGE))

	// the motor is off on the stop tick
	`CST_ASSERT_ALWAYS(a_stop_motor_off,
		!(rsp_valid && rsp_data.stop_event) || !rsp_data.motor_on)

	// input stalls only while the output side is blocked
	`CST_ASSERT_ALWAYS(a_stall_cause, !req_stall || (rsp_valid && rsp_stall))

endmodule

bind conveyor_sort_tracker cst_checker u_cst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
